// ===== design/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// Shared concurrent assertion macros, clocked on clk, disabled in reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication: cons must hold whenever ante holds.
`define ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication: cons must hold in the cycle after ante.
`define ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// ===== design/rsf_pkg.sv =====
// ----------------------------------------------------------------------------
// rsf_pkg
// Constants, register map and helpers of the record substring filter.
// ----------------------------------------------------------------------------
package rsf_pkg;

  localparam int CHAR_W              = 8;
  localparam int PAT_LEN_W           = 5;
  localparam int PAT_WORD_W          = 64;
  localparam int PAT_WORDS           = 3;
  localparam int PAT_ALL_W           = PAT_WORDS * PAT_WORD_W;
  localparam int CFG_DATA_W          = 64;
  localparam int CFG_ADDR_W          = 5;
  localparam int CFG_IDX_LSB         = 3;
  localparam int DEFAULT_MAX_PATTERN = 24;
  localparam int DEFAULT_MAX_RECORDS = 2048;

  localparam logic [CHAR_W-1:0] CHAR_UPPER_A = 8'h41;
  localparam logic [CHAR_W-1:0] CHAR_UPPER_Z = 8'h5A;
  localparam logic [CHAR_W-1:0] CASE_OFFSET  = 8'd32;

  typedef enum logic [1:0] {
    REG_PAT_LEN  = 2'd0,
    REG_PAT_LOW  = 2'd1,
    REG_PAT_MID  = 2'd2,
    REG_PAT_HIGH = 2'd3
  } reg_index_t;

  // Fold A-Z onto a-z; every other byte passes unchanged.
  function automatic logic [CHAR_W-1:0] fold_case(input logic [CHAR_W-1:0] c);
    logic [CHAR_W-1:0] r;
    r = c;
    if (c inside {[CHAR_UPPER_A:CHAR_UPPER_Z]}) begin
      r = c + CASE_OFFSET;
    end
    return r;
  endfunction

endpackage

// ===== design/record_substring_filter.sv =====
// ----------------------------------------------------------------------------
// record_substring_filter
// Case-insensitive substring filter over a stream of record bytes.
// ----------------------------------------------------------------------------
// Usage:
//   Record bytes enter on the text channel (text_valid / text_stall) with
//   field_last, record_last and pass_last marks. A zero byte ends a field's
//   text. On the last byte of every record one transfer leaves on the result
//   channel (result_valid / result_stall) carrying record_index, matched and
//   the running hit_count of the pass.
//   The pattern (length plus three 64-bit character words) is written over
//   the APB port at byte addresses 0, 8, 16 and 24 while the block is idle.
// Timing:
//   Throughput is one byte per cycle while no record-ending byte is held by a
//   stalled result: each byte costs a single shift-and update of the match
//   vector, done between the input register and the result register. A
//   record's result passes the input register, then the result register.
// Reset (rst, synchronous): clears the pattern, the match state and both
//   counters; no result is pending afterwards.
// Stall: a stalled result holds in the output register; bytes that end no
//   record keep flowing, and a record-ending byte waits in the input register.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module record_substring_filter #(
  parameter int MAX_PATTERN = rsf_pkg::DEFAULT_MAX_PATTERN,
  parameter int MAX_RECORDS = rsf_pkg::DEFAULT_MAX_RECORDS
) (
  input  logic                                clk,
  input  logic                                rst,
  // configuration port
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [rsf_pkg::CFG_ADDR_W-1:0]      paddr,
  input  logic [rsf_pkg::CFG_DATA_W-1:0]      pwdata,
  output logic [rsf_pkg::CFG_DATA_W-1:0]      prdata,
  output logic                                pready,
  // text byte channel
  input  logic                                text_valid,
  output logic                                text_stall,
  input  logic [rsf_pkg::CHAR_W-1:0]          text_byte,
  input  logic                                field_last,
  input  logic                                record_last,
  input  logic                                pass_last,
  // result channel
  output logic                                result_valid,
  input  logic                                result_stall,
  output logic [$clog2(MAX_RECORDS)-1:0]      record_index,
  output logic                                matched,
  output logic [$clog2(MAX_RECORDS+1)-1:0]    hit_count
);

  import rsf_pkg::*;

  localparam int REC_W   = $clog2(MAX_RECORDS);
  localparam int CNT_W   = $clog2(MAX_RECORDS + 1);
  localparam int VEC_W   = MAX_PATTERN;
  localparam int CHARS_W = MAX_PATTERN * CHAR_W;

  // --------------------------------------------------------------------------
  // Configuration registers
  // --------------------------------------------------------------------------
  logic [PAT_LEN_W-1:0]  pattern_length;
  logic [PAT_WORD_W-1:0] pattern_low;
  logic [PAT_WORD_W-1:0] pattern_mid;
  logic [PAT_WORD_W-1:0] pattern_high;

  reg_index_t cfg_index;
  logic       cfg_write;

  assign pready    = 1'b1;
  assign cfg_index = reg_index_t'(paddr[CFG_ADDR_W-1:CFG_IDX_LSB]);
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      pattern_length <= '0;
      pattern_low    <= '0;
      pattern_mid    <= '0;
      pattern_high   <= '0;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_PAT_LEN:  pattern_length <= pwdata[PAT_LEN_W-1:0];
        REG_PAT_LOW:  pattern_low    <= pwdata;
        REG_PAT_MID:  pattern_mid    <= pwdata;
        REG_PAT_HIGH: pattern_high   <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_index)
      REG_PAT_LEN:  prdata = CFG_DATA_W'(pattern_length);
      REG_PAT_LOW:  prdata = pattern_low;
      REG_PAT_MID:  prdata = pattern_mid;
      REG_PAT_HIGH: prdata = pattern_high;
      default:      prdata = '0;
    endcase
  end

  // --------------------------------------------------------------------------
  // Pattern decode: characters past the registers read as zero, the pattern
  // ends at its first zero character, and the length clamps to capacity.
  // --------------------------------------------------------------------------
  logic [PAT_ALL_W-1:0] pattern_all;
  logic [CHARS_W-1:0]   pattern_chars;
  logic [PAT_LEN_W-1:0] len_clamp;
  logic [PAT_LEN_W-1:0] eff_len;
  logic [VEC_W-1:0]     last_sel;

  assign pattern_all   = {pattern_high, pattern_mid, pattern_low};
  assign pattern_chars = CHARS_W'(pattern_all);

  always_comb begin
    if (32'(pattern_length) > MAX_PATTERN) begin
      len_clamp = PAT_LEN_W'(MAX_PATTERN);
    end else begin
      len_clamp = pattern_length;
    end
    eff_len = len_clamp;
    for (int k = VEC_W - 1; k >= 0; k--) begin
      if (k < int'(len_clamp) && pattern_chars[k*CHAR_W +: CHAR_W] == '0) begin
        eff_len = PAT_LEN_W'(k);
      end
    end
    for (int k = 0; k < VEC_W; k++) begin
      last_sel[k] = (k + 1 == int'(eff_len));
    end
  end

  // --------------------------------------------------------------------------
  // Input register
  // --------------------------------------------------------------------------
  logic              s1_valid;
  logic [CHAR_W-1:0] s1_byte;
  logic              s1_field_last;
  logic              s1_record_last;
  logic              s1_pass_last;
  logic              s1_hold;
  logic              s1_fire;
  logic              s1_result;

  // Only a record-ending byte needs the output register.
  assign s1_hold    = s1_valid && s1_record_last && result_valid && result_stall;
  assign s1_fire    = s1_valid && !s1_hold;
  assign s1_result  = s1_fire && s1_record_last;
  assign text_stall = s1_hold;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (!text_stall) begin
      s1_valid <= text_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (text_valid && !text_stall) begin
      s1_byte        <= text_byte;
      s1_field_last  <= field_last;
      s1_record_last <= record_last;
      s1_pass_last   <= pass_last;
    end
  end

  // --------------------------------------------------------------------------
  // Shift-and match update, one byte per cycle while the input is not stalled
  // --------------------------------------------------------------------------
  logic [VEC_W-1:0] partial_matches;
  logic [VEC_W-1:0] partial_matches_next;
  logic             text_done;
  logic             text_done_next;
  logic             record_hit;
  logic             record_hit_next;
  logic [VEC_W-1:0] char_mask;
  logic [CHAR_W-1:0] byte_folded;
  logic             record_match;
  logic [REC_W-1:0] record_count;
  logic [CNT_W-1:0] match_count;
  logic [CNT_W-1:0] match_count_next;

  assign byte_folded = fold_case(s1_byte);

  always_comb begin
    for (int k = 0; k < VEC_W; k++) begin
      char_mask[k] = (k < int'(eff_len)) &&
                     (fold_case(pattern_chars[k*CHAR_W +: CHAR_W]) == byte_folded);
    end
  end

  always_comb begin
    partial_matches_next = partial_matches;
    text_done_next       = text_done;
    record_hit_next      = record_hit;
    if (!text_done) begin
      if (s1_byte == '0) begin
        text_done_next = 1'b1;
      end else if (eff_len != '0) begin
        partial_matches_next = ((partial_matches << 1) | VEC_W'(1)) & char_mask;
        if (|(partial_matches_next & last_sel)) begin
          record_hit_next = 1'b1;
        end
      end
    end
    record_match = record_hit_next || (eff_len == '0);
    // a field end, or a record end, drops the field's match state
    if (s1_field_last || s1_record_last) begin
      partial_matches_next = '0;
      text_done_next       = 1'b0;
    end
    if (s1_record_last) begin
      record_hit_next = 1'b0;
    end
    // saturate the hit count at the record capacity
    if (record_match && match_count != CNT_W'(MAX_RECORDS)) begin
      match_count_next = match_count + CNT_W'(1);
    end else begin
      match_count_next = match_count;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      partial_matches <= '0;
      text_done       <= 1'b0;
      record_hit      <= 1'b0;
    end else if (s1_fire) begin
      partial_matches <= partial_matches_next;
      text_done       <= text_done_next;
      record_hit      <= record_hit_next;
    end
  end

  // Advance the record index with wrap; clear both counters at pass end.
  always_ff @(posedge clk) begin
    if (rst) begin
      record_count <= '0;
      match_count  <= '0;
    end else if (s1_result) begin
      if (s1_pass_last) begin
        record_count <= '0;
        match_count  <= '0;
      end else begin
        match_count <= match_count_next;
        if (record_count == REC_W'(MAX_RECORDS - 1)) begin
          record_count <= '0;
        end else begin
          record_count <= record_count + REC_W'(1);
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Result register
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (s1_result) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_result) begin
      record_index <= record_count;
      matched      <= record_match;
      hit_count    <= match_count_next;
    end
  end

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  `ASSERT_NEXT(a_result_loaded, s1_result, result_valid)
  `ASSERT_NEXT(a_field_end_clears, s1_fire && (s1_field_last || s1_record_last),
               partial_matches == '0 && !text_done)
  `ASSERT_NEXT(a_empty_pattern_hits, s1_result && eff_len == '0, matched)
  `ASSERT_IMPL(a_hit_counted, result_valid && matched, hit_count != '0)

endmodule

// ===== tb/tb_record_substring_filter.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_record_substring_filter
// Self-checking bench for the case-insensitive record substring filter.
// Record bytes are generated as well-formed fields with the pattern embedded
// in random letter case, mixed with noise and malformed records. A scoreboard
// runs its own shift-and search on every accepted byte and compares each
// record result field by field. Text gaps and result stalls come at random.
// ----------------------------------------------------------------------------
module tb_record_substring_filter;
  import rsf_pkg::*;

  localparam int PAT_MAX     = DEFAULT_MAX_PATTERN;
  localparam int REC_MAX     = DEFAULT_MAX_RECORDS;
  localparam int IDX_W       = $clog2(REC_MAX);
  localparam int CNT_W       = $clog2(REC_MAX+1);
  // Drain wait: covers the input and result registers, with slack on top.
  localparam int DRAIN       = 8;
  localparam int PHASE_ITEMS = 50;
  localparam int TAIL_RECS   = 12;

  typedef struct packed {
    logic [CHAR_W-1:0] data;
    logic              fld_end;
    logic              rec_end;
    logic              pass_end;
  } text_beat_t;

  typedef struct {
    logic [IDX_W-1:0] idx;
    logic             hit;
    logic [CNT_W-1:0] count;
  } record_verdict_t;

  // Holds a private copy of the pattern registers and the search state, and
  // the verdicts still owed by the block, oldest first.
  class filter_scoreboard;
    logic [PAT_LEN_W-1:0]  pat_len;
    logic [PAT_WORD_W-1:0] pat_word [PAT_WORDS];
    logic [PAT_MAX-1:0]    prefix_vec;
    bit                    text_done;
    bit                    rec_hit;
    logic [IDX_W-1:0]      rec_idx;
    logic [CNT_W-1:0]      hits;
    record_verdict_t       verdicts [$];
    int                    errors;

    function new();
      pat_len    = '0;
      foreach (pat_word[i]) pat_word[i] = '0;
      prefix_vec = '0;
      text_done  = 0;
      rec_hit    = 0;
      rec_idx    = '0;
      hits       = '0;
      errors     = 0;
    endfunction

    function void write_reg(reg_index_t idx, logic [CFG_DATA_W-1:0] v);
      case (idx)
        REG_PAT_LEN:  pat_len     = v[PAT_LEN_W-1:0];
        REG_PAT_LOW:  pat_word[0] = v;
        REG_PAT_MID:  pat_word[1] = v;
        REG_PAT_HIGH: pat_word[2] = v;
        default: ;
      endcase
    endfunction

    function logic [CHAR_W-1:0] pat_char(int k);
      logic [PAT_ALL_W-1:0] flat;
      flat = {pat_word[2], pat_word[1], pat_word[0]};
      if (k >= PAT_MAX) return '0;
      return flat[CHAR_W*k +: CHAR_W];
    endfunction

    // Clamp to capacity, then cut at the first zero character.
    function int eff_len();
      int n;
      n = pat_len;
      if (n > PAT_MAX) n = PAT_MAX;
      for (int k = 0; k < n; k++) begin
        if (pat_char(k) == '0) return k;
      end
      return n;
    endfunction

    function logic [CHAR_W-1:0] to_lower(logic [CHAR_W-1:0] c);
      if (c >= CHAR_UPPER_A && c <= CHAR_UPPER_Z) return c + CASE_OFFSET;
      return c;
    endfunction

    function void note_text(text_beat_t t);
      int                 len;
      logic [PAT_MAX-1:0] mask;
      bit                 hit;
      record_verdict_t    v;
      len = eff_len();
      if (!text_done) begin
        if (t.data == '0) begin
          text_done = 1;
        end else if (len > 0) begin
          mask = '0;
          for (int k = 0; k < len; k++) begin
            if (to_lower(pat_char(k)) == to_lower(t.data)) mask[k] = 1'b1;
          end
          prefix_vec = ((prefix_vec << 1) | PAT_MAX'(1)) & mask;
          if (prefix_vec[len-1]) rec_hit = 1;
        end
      end
      if (t.fld_end || t.rec_end) begin
        prefix_vec = '0;
        text_done  = 0;
      end
      if (!t.rec_end) return;
      hit = rec_hit || len == 0;
      if (hit && hits < REC_MAX) hits++;
      v.idx   = rec_idx;
      v.hit   = hit;
      v.count = hits;
      verdicts.push_back(v);
      rec_hit = 0;
      rec_idx = (rec_idx == REC_MAX - 1) ? '0 : rec_idx + 1'b1;
      if (t.pass_end) begin
        rec_idx = '0;
        hits    = '0;
      end
    endfunction

    function void check_result(record_verdict_t got);
      record_verdict_t want;
      if (verdicts.size() == 0) begin
        $error("unexpected result: record_index %0d matched %0d hit_count %0d",
               got.idx, got.hit, got.count);
        errors++;
        return;
      end
      want = verdicts.pop_front();
      if (got.idx !== want.idx) begin
        $error("record_index: expected %0d, actual %0d", want.idx, got.idx);
        errors++;
      end
      if (got.hit !== want.hit) begin
        $error("matched: expected %0d, actual %0d", want.hit, got.hit);
        errors++;
      end
      if (got.count !== want.count) begin
        $error("hit_count: expected %0d, actual %0d", want.count, got.count);
        errors++;
      end
    endfunction
  endclass

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  psel = 1'b0;
  logic                  penable = 1'b0;
  logic                  pwrite = 1'b0;
  logic [CFG_ADDR_W-1:0] paddr = '0;
  logic [CFG_DATA_W-1:0] pwdata = '0;
  logic [CFG_DATA_W-1:0] prdata;
  logic                  pready;
  logic                  text_valid = 1'b0;
  logic                  text_stall;
  logic [CHAR_W-1:0]     text_byte = '0;
  logic                  field_last = 1'b0;
  logic                  record_last = 1'b0;
  logic                  pass_last = 1'b0;
  logic                  result_valid;
  logic                  result_stall = 1'b0;
  logic [IDX_W-1:0]      record_index;
  logic                  matched;
  logic [CNT_W-1:0]      hit_count;

  filter_scoreboard sb = new();
  text_beat_t       text_q [$];   // bytes waiting to be offered to the block
  int               hold_left = 0; // long receiver hold-off, counted by the sink

  record_substring_filter dut (
    .clk          (clk),
    .rst          (rst),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready),
    .text_valid   (text_valid),
    .text_stall   (text_stall),
    .text_byte    (text_byte),
    .field_last   (field_last),
    .record_last  (record_last),
    .pass_last    (pass_last),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .record_index (record_index),
    .matched      (matched),
    .hit_count    (hit_count)
  );

  always begin
    clk = 1'b0;
    #1;
    clk = 1'b1;
    #1;
  end

  // Hard stop far beyond the slowest legal run.
  initial begin
    #1000000;
    $display("Mismatches found");
    $finish;
  end

  // Text source: offer queued bytes in bursts of random length, with random
  // gaps between bursts. A stalled byte holds until its transfer completes.
  initial begin : text_source
    text_beat_t beat;
    int         burst_left;
    int         gap_left;
    burst_left = $urandom_range(1, 24);
    gap_left   = 0;
    forever begin
      @(posedge clk);
      if (text_valid && !text_stall) begin
        sb.note_text({text_byte, field_last, record_last, pass_last});
      end
      if (!text_valid || !text_stall) begin
        if (gap_left > 0) begin
          gap_left--;
          text_valid <= 1'b0;
        end else if (text_q.size() != 0) begin
          beat = text_q.pop_front();
          text_byte   <= beat.data;
          field_last  <= beat.fld_end;
          record_last <= beat.rec_end;
          pass_last   <= beat.pass_end;
          text_valid  <= 1'b1;
          burst_left--;
          if (burst_left <= 0) begin
            burst_left = $urandom_range(1, 24);
            // About one burst in four runs straight into the next one.
            gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
          end
        end else begin
          text_valid <= 1'b0;
        end
      end
    end
  end

  // Result sink: check every transfer, and stall on a pattern of its own that
  // switches between free flow, light and heavy random stalls and a periodic
  // duty cycle. A requested hold-off overrides all of these.
  initial begin : result_sink
    record_verdict_t got;
    int              mode;
    int              mode_left;
    mode      = 0;
    mode_left = 0;
    forever begin
      @(posedge clk);
      if (result_valid === 1'b1 && result_stall === 1'b0) begin
        got.idx   = record_index;
        got.hit   = matched;
        got.count = hit_count;
        sb.check_result(got);
      end
      if (mode_left <= 0) begin
        mode      = $urandom_range(0, 3);
        mode_left = $urandom_range(16, 96);
      end
      mode_left--;
      if (hold_left > 0) begin
        hold_left--;
        result_stall <= 1'b1;
      end else begin
        case (mode)
          0: result_stall <= 1'b0;
          1: result_stall <= ($urandom_range(0, 3) == 0);
          2: result_stall <= ($urandom_range(0, 3) != 0);
          default: result_stall <= (mode_left % 3 != 0);
        endcase
      end
    end
  end

  // Setup cycle, then access cycle; the register takes the value at the edge
  // where the access phase sees pready.
  task automatic cfg_write(reg_index_t idx, logic [CFG_DATA_W-1:0] v);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= CFG_ADDR_W'(int'(idx) << CFG_IDX_LSB);
    pwdata  <= v;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (pready !== 1'b1) @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    sb.write_reg(idx, v);
  endtask

  task automatic set_pattern(int len, logic [CFG_DATA_W-1:0] lo,
                             logic [CFG_DATA_W-1:0] mid, logic [CFG_DATA_W-1:0] hi);
    cfg_write(REG_PAT_LEN, CFG_DATA_W'(len));
    cfg_write(REG_PAT_LOW, lo);
    cfg_write(REG_PAT_MID, mid);
    cfg_write(REG_PAT_HIGH, hi);
  endtask

  // Wait until every byte has gone in and every verdict has come out, then
  // let the pipeline settle so that no byte is still in flight. Look again
  // after settling, since the source may pick up a last byte at the very
  // edge where the queue looked empty.
  task automatic wait_idle();
    do begin
      while (text_q.size() != 0 || text_valid || sb.verdicts.size() != 0) begin
        @(posedge clk);
      end
      repeat (DRAIN) @(posedge clk);
    end while (text_q.size() != 0 || text_valid || sb.verdicts.size() != 0);
  endtask

  function automatic void push_beat(logic [CHAR_W-1:0] c, bit fl, bit rl, bit pl);
    text_q.push_back({c, fl, rl, pl});
  endfunction

  // Bias toward letters in both cases, their neighbors that must not fold,
  // and bytes above 127.
  function automatic logic [CHAR_W-1:0] pick_char();
    logic [CHAR_W-1:0] alphabet [12] = '{8'h61, 8'h42, 8'h7A, 8'h5A, 8'h40, 8'h60,
                                         8'h5B, 8'h7B, 8'h80, 8'hC1, 8'hE1, 8'hFF};
    if ($urandom_range(0, 3) == 0) return CHAR_W'($urandom_range(1, 255));
    return alphabet[$urandom_range(0, 11)];
  endfunction

  function automatic logic [CHAR_W-1:0] flip_case(logic [CHAR_W-1:0] c);
    bit letter;
    letter = (c >= 8'h41 && c <= 8'h5A) || (c >= 8'h61 && c <= 8'h7A);
    if (letter && $urandom_range(0, 1) == 1) return c ^ 8'h20;
    return c;
  endfunction

  // Build one record of one to three fields. About half the fields carry the pattern
  // in random letter case, some with one character spoiled, and noise around it
  // that may hold a zero byte. About one record in ten is plain noise with
  // random marks.
  task automatic gen_record();
    logic [CHAR_W-1:0] fb [$];
    int                n_fields;
    int                len;
    int                n;
    bit                fl;
    bit                rl;
    bit                pl;
    len = sb.eff_len();
    if ($urandom_range(0, 9) == 0) begin
      n = $urandom_range(1, 6);
      for (int i = 0; i < n; i++) begin
        push_beat(CHAR_W'($urandom_range(0, 255)), $urandom_range(0, 1),
                  $urandom_range(0, 1), $urandom_range(0, 1));
      end
      return;
    end
    n_fields = $urandom_range(1, 3);
    for (int f = 0; f < n_fields; f++) begin
      fb.delete();
      n = $urandom_range(0, 4);
      for (int i = 0; i < n; i++) begin
        fb.push_back(($urandom_range(0, 11) == 0) ? '0 : pick_char());
      end
      if (len > 0 && $urandom_range(0, 1) == 1) begin
        for (int k = 0; k < len; k++) fb.push_back(flip_case(sb.pat_char(k)));
        if ($urandom_range(0, 4) == 0) begin
          fb[fb.size() - 1 - $urandom_range(0, len - 1)] = pick_char();
        end
      end
      n = $urandom_range(0, 3);
      for (int i = 0; i < n; i++) begin
        fb.push_back(($urandom_range(0, 11) == 0) ? '0 : pick_char());
      end
      if (fb.size() == 0) fb.push_back(pick_char());
      foreach (fb[i]) begin
        rl = (f == n_fields - 1) && (i == fb.size() - 1);
        fl = (i == fb.size() - 1) && (!rl || $urandom_range(0, 1) == 1);
        // A pass mark off the record end must be ignored.
        pl = rl ? ($urandom_range(0, 11) == 0) : ($urandom_range(0, 15) == 0);
        push_beat(fb[i], fl, rl, pl);
      end
    end
  endtask

  task automatic run_random_phase();
    while (text_q.size() < PHASE_ITEMS) gen_record();
  endtask

  // Pack a pattern into the three character words, up to capacity.
  task automatic set_char_pattern(int len, logic [CHAR_W-1:0] chars [PAT_MAX]);
    logic [PAT_ALL_W-1:0] flat;
    foreach (chars[k]) flat[CHAR_W*k +: CHAR_W] = chars[k];
    set_pattern(len, flat[0 +: PAT_WORD_W], flat[PAT_WORD_W +: PAT_WORD_W],
                flat[2*PAT_WORD_W +: PAT_WORD_W]);
  endtask

  initial begin : main_seq
    logic [CHAR_W-1:0] chars [PAT_MAX];
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Empty pattern matches every record, even one with a zero byte first.
    set_pattern(0, '0, '0, '0);
    push_beat(8'h00, 1, 0, 0);
    push_beat(8'hFF, 0, 1, 0);
    wait_idle();

    // Pattern "AbC".
    set_pattern(3, 64'h0000_0000_0043_6241, '0, '0);
    // Opposite letter case still matches.
    push_beat("a", 0, 0, 0); push_beat("B", 0, 0, 0); push_beat("c", 0, 1, 0);
    // Split across a field boundary: no match.
    push_beat("a", 0, 0, 0); push_beat("b", 1, 0, 0); push_beat("c", 0, 1, 0);
    // Zero byte ends the text; the rest of the field is ignored.
    push_beat("a", 0, 0, 0); push_beat(8'h00, 0, 0, 0);
    push_beat("b", 0, 0, 0); push_beat("c", 1, 1, 0);
    // Pass mark inside a record is ignored; match lies within one field.
    push_beat("x", 0, 0, 1); push_beat("A", 0, 0, 0);
    push_beat("b", 0, 0, 1); push_beat("C", 0, 1, 0);
    // Record end without a field end still clears the partial match.
    push_beat("x", 0, 0, 0); push_beat("a", 0, 0, 0); push_beat("b", 0, 1, 0);
    push_beat("c", 1, 1, 0);
    // Close the pass: counters clear after this record.
    push_beat("A", 0, 0, 0); push_beat("B", 0, 0, 0); push_beat("C", 1, 1, 1);
    push_beat("c", 0, 1, 0);
    wait_idle();

    // Length above capacity with a full, all-nonzero pattern.
    foreach (chars[k]) chars[k] = pick_char();
    set_char_pattern(31, chars);
    run_random_phase();
    wait_idle();

    // Zero character early in the pattern shortens it.
    foreach (chars[k]) chars[k] = pick_char();
    chars[$urandom_range(1, 6)] = '0;
    set_char_pattern(PAT_MAX, chars);
    run_random_phase();
    wait_idle();

    // Nonzero length over all-zero characters: effectively empty.
    set_pattern(20, '0, '0, '0);
    run_random_phase();
    wait_idle();

    // All-ones characters: a run of 0xFF bytes, compared exactly.
    set_pattern(5, '1, '1, '1);
    run_random_phase();
    wait_idle();

    // Single character.
    foreach (chars[k]) chars[k] = pick_char();
    set_char_pattern(1, chars);
    run_random_phase();
    wait_idle();

    // Short pattern; hold the sink off for a long stretch so the block fills
    // and stalls its input while bytes keep coming.
    foreach (chars[k]) chars[k] = pick_char();
    set_char_pattern($urandom_range(2, 4), chars);
    run_random_phase();
    run_random_phase();
    hold_left = 400;
    wait_idle();

    // One-byte records with an empty pattern, then end the pass and start
    // a fresh one.
    set_pattern(0, '1, '1, '1);
    for (int r = 0; r < TAIL_RECS; r++) begin
      push_beat(CHAR_W'($urandom_range(0, 255)), $urandom_range(0, 1), 1, 0);
    end
    push_beat(CHAR_W'($urandom_range(0, 255)), 1, 1, 1);
    push_beat(CHAR_W'($urandom_range(0, 255)), 1, 1, 0);
    wait_idle();

    if (sb.errors == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end
endmodule

// ===== sim.f =====
+incdir+design
design/rsf_pkg.sv
design/record_substring_filter.sv
tb/tb_record_substring_filter.sv
